/* rtl/tcfp_pkg.sv */
// Package: byte codes, result kinds and result item layout for the frame parser.
package tcfp_pkg;

  // Frame framing bytes
  localparam logic [7:0] HdrRing  = 8'hAA;
  localparam logic [7:0] HdrCid   = 8'hCC;
  localparam logic [7:0] HdrCxy   = 8'hDD;
  localparam logic [7:0] Trailer  = 8'hBB;

  // Completion kinds reported in frame_done
  typedef enum logic [1:0] {
    DONE_NONE = 2'd0,
    DONE_RING = 2'd1,
    DONE_CID  = 2'd2,
    DONE_CXY  = 2'd3
  } done_kind_e;

  // One result item, fields listed from the highest tdata bit down
  typedef struct packed {
    logic [15:0] colour_y;
    logic [15:0] colour_x;
    logic [7:0]  colour_id;
    logic [15:0] ring_y;
    logic [15:0] ring_x;
    logic [1:0]  frame_done;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);
  localparam int unsigned OutBytes   = (ResultBits + 7) / 8;
  localparam int unsigned OutBits    = OutBytes * 8;
  localparam int unsigned PadBits    = OutBits - ResultBits;

endpackage

/* rtl/tagged_coordinate_frame_parser.sv */
// Top level: header/payload/trailer byte parser with a registered, skid-buffered result.
// Each accepted byte gives one result item, held in the output or the skid register.
// One byte per cycle with the skid empty; each byte updates the parse state in one pass.
// A one-entry skid register takes one more byte while the master side stalls.
// Reset (rst_ni low, asynchronous): parser idle, latched coordinates and ID zero,
// no result pending.
module tagged_coordinate_frame_parser
  import tcfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] rx_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OutBits-1:0] m_axis_tdata_o    // frame_done, ring_x, ring_y, colour_id,
                                               // colour_x, colour_y, zero pad
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RING_PAY = 3'd1,
    PH_RING_END = 3'd2,
    PH_CID_PAY  = 3'd3,
    PH_CID_END  = 3'd4,
    PH_CXY_PAY  = 3'd5,
    PH_CXY_END  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  buf_q [3];
  logic [15:0] ring_x_q, ring_x_d;
  logic [15:0] ring_y_q, ring_y_d;
  logic [7:0]  cid_q, cid_d;
  logic [15:0] cxy_x_q, cxy_x_d;
  logic [15:0] cxy_y_q, cxy_y_d;
  done_kind_e  done;

  result_t     res;
  result_t     out_q, skid_q;
  logic        out_vld_q, skid_vld_q;
  logic        accept;
  logic        out_free;
  logic [7:0]  rx;

  assign rx       = s_axis_tdata_i;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Next parse state for the byte on the slave side
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    ring_x_d = ring_x_q;
    ring_y_d = ring_y_q;
    cid_d    = cid_q;
    cxy_x_d  = cxy_x_q;
    cxy_y_d  = cxy_y_q;
    done     = DONE_NONE;
    case (phase_q)
      PH_RING_PAY: begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          ring_x_d = {buf_q[0], buf_q[1]};
          ring_y_d = {buf_q[2], rx};
          phase_d  = PH_RING_END;
        end
      end
      PH_CID_PAY: begin
        idx_d   = idx_q + 2'd1;
        cid_d   = rx;
        phase_d = PH_CID_END;
      end
      PH_CXY_PAY: begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          cxy_x_d = {buf_q[0], buf_q[1]};
          cxy_y_d = {buf_q[2], rx};
          phase_d = PH_CXY_END;
        end
      end
      PH_RING_END: begin
        if (rx == Trailer) begin
          phase_d = PH_IDLE;
          done    = DONE_RING;
        end
      end
      PH_CID_END: begin
        if (rx == Trailer) begin
          phase_d = PH_IDLE;
          done    = DONE_CID;
        end
      end
      PH_CXY_END: begin
        if (rx == Trailer) begin
          phase_d = PH_IDLE;
          done    = DONE_CXY;
        end
      end
      default: begin
        // Idle: look for a header, drop anything else
        if (rx == HdrRing) begin
          phase_d = PH_RING_PAY;
          idx_d   = 2'd0;
        end else if (rx == HdrCid) begin
          phase_d = PH_CID_PAY;
          idx_d   = 2'd0;
        end else if (rx == HdrCxy) begin
          phase_d = PH_CXY_PAY;
          idx_d   = 2'd0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  // Assemble the result item from the updated state
  always_comb begin
    res.frame_done = done;
    res.ring_x     = ring_x_d;
    res.ring_y     = ring_y_d;
    res.colour_id  = cid_d;
    res.colour_x   = cxy_x_d;
    res.colour_y   = cxy_y_d;
  end

  // Advance the parse state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      idx_q    <= 2'd0;
      ring_x_q <= '0;
      ring_y_q <= '0;
      cid_q    <= '0;
      cxy_x_q  <= '0;
      cxy_y_q  <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      ring_x_q <= ring_x_d;
      ring_y_q <= ring_y_d;
      cid_q    <= cid_d;
      cxy_x_q  <= cxy_x_d;
      cxy_y_q  <= cxy_y_d;
    end
  end

  // Hold the first three coordinate bytes; the fourth is used as it arrives
  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == PH_RING_PAY || phase_q == PH_CXY_PAY) && idx_q != 2'd3) begin
      buf_q[idx_q] <= rx;
    end
  end

  // Output register with a one-entry skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= accept;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready_o = !skid_vld_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{PadBits{1'b0}}, out_q};

  // A waiting skid item always has a result in front of it
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while output register empty");

  // A completion is reported only for a trailer byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done != DONE_NONE) |-> (rx == Trailer))
    else $error("completion without trailer byte");

  // After a completion the parser is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done != DONE_NONE) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after completion");

  // A stalled skid item is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !m_axis_tready_i) |=> skid_vld_q)
    else $error("skid item lost under stall");

endmodule

/* tb/tagged_coordinate_frame_parser_tb.sv */
// Testbench for the tagged coordinate frame parser: byte stream in, checked result stream out.
`timescale 1ns / 100ps

module tagged_coordinate_frame_parser_tb;
  import tcfp_pkg::*;

  // Parse phases of the frame parser
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RING_PAY = 3'd1,
    PH_RING_END = 3'd2,
    PH_CID_PAY  = 3'd3,
    PH_CID_END  = 3'd4,
    PH_CXY_PAY  = 3'd5,
    PH_CXY_END  = 3'd6
  } parse_phase_e;

  // Shapes of a generated frame: whole or cut short
  typedef enum int {
    FRAME_WHOLE,
    FRAME_TRUNCATED,
    FRAME_NO_TRAILER
  } frame_shape_e;

  localparam int unsigned CycleLimit = 100000;

  // Scoreboard: predicts the result item of every accepted byte and checks the output
  class frame_scoreboard;
    parse_phase_e phase;
    logic [2:0]   pay_idx;
    logic [7:0]   pay_bytes [4];
    logic [15:0]  ring_x, ring_y, colour_x, colour_y;
    logic [7:0]   colour_id;
    result_t      expected_q [$];
    int unsigned  mismatches, checked, bytes_seen;
    int unsigned  kind_count [4];

    function new();
      phase     = PH_IDLE;
      pay_idx   = '0;
      foreach (pay_bytes[i]) pay_bytes[i] = '0;
      ring_x    = '0;
      ring_y    = '0;
      colour_id = '0;
      colour_x  = '0;
      colour_y  = '0;
      mismatches = 0;
      checked    = 0;
      bytes_seen = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    // Store one payload byte; true once the frame's payload is complete
    function bit take_payload(logic [7:0] b, logic [2:0] need);
      pay_bytes[pay_idx[1:0]] = b;
      pay_idx = pay_idx + 3'd1;
      return pay_idx >= need;
    endfunction

    // Advance the parser by one accepted byte and queue the resulting item
    function void note_byte(logic [7:0] b);
      done_kind_e done;
      result_t    r;
      done = DONE_NONE;
      bytes_seen++;
      case (phase)
        PH_RING_PAY: if (take_payload(b, 3'd4)) begin
          ring_x = {pay_bytes[0], pay_bytes[1]};
          ring_y = {pay_bytes[2], pay_bytes[3]};
          phase  = PH_RING_END;
        end
        PH_CID_PAY: if (take_payload(b, 3'd1)) begin
          colour_id = pay_bytes[0];
          phase     = PH_CID_END;
        end
        PH_CXY_PAY: if (take_payload(b, 3'd4)) begin
          colour_x = {pay_bytes[0], pay_bytes[1]};
          colour_y = {pay_bytes[2], pay_bytes[3]};
          phase    = PH_CXY_END;
        end
        PH_RING_END: if (b == Trailer) begin
          phase = PH_IDLE;
          done  = DONE_RING;
        end
        PH_CID_END: if (b == Trailer) begin
          phase = PH_IDLE;
          done  = DONE_CID;
        end
        PH_CXY_END: if (b == Trailer) begin
          phase = PH_IDLE;
          done  = DONE_CXY;
        end
        default: begin
          if (b == HdrRing) begin
            phase   = PH_RING_PAY;
            pay_idx = '0;
          end else if (b == HdrCid) begin
            phase   = PH_CID_PAY;
            pay_idx = '0;
          end else if (b == HdrCxy) begin
            phase   = PH_CXY_PAY;
            pay_idx = '0;
          end else begin
            phase = PH_IDLE;
          end
        end
      endcase
      r.frame_done = done;
      r.ring_x     = ring_x;
      r.ring_y     = ring_y;
      r.colour_id  = colour_id;
      r.colour_x   = colour_x;
      r.colour_y   = colour_y;
      expected_q.push_back(r);
    endfunction

    function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    endfunction

    // Compare one output item against the oldest expectation
    function void check_result(logic [OutBits-1:0] word);
      result_t act, exp_r;
      act = word[ResultBits-1:0];
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing expected, expected none actual %h", $time, word);
        return;
      end
      exp_r = expected_q.pop_front();
      if (act.frame_done !== exp_r.frame_done)
        report("frame_done", 16'(exp_r.frame_done), 16'(act.frame_done));
      if (act.ring_x !== exp_r.ring_x) report("ring_x", exp_r.ring_x, act.ring_x);
      if (act.ring_y !== exp_r.ring_y) report("ring_y", exp_r.ring_y, act.ring_y);
      if (act.colour_id !== exp_r.colour_id)
        report("colour_id", 16'(exp_r.colour_id), 16'(act.colour_id));
      if (act.colour_x !== exp_r.colour_x) report("colour_x", exp_r.colour_x, act.colour_x);
      if (act.colour_y !== exp_r.colour_y) report("colour_y", exp_r.colour_y, act.colour_y);
      if (word[OutBits-1:ResultBits] !== '0)
        report("pad", 16'd0, 16'(word[OutBits-1:ResultBits]));
      if (exp_r.frame_done != DONE_NONE) kind_count[exp_r.frame_done]++;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [OutBits-1:0] m_axis_tdata_o;

  frame_scoreboard sb = new();
  logic [7:0]      stim_q [$];
  int unsigned     burst_left;
  int unsigned     cycle_count;
  int unsigned     stall_mode;

  tagged_coordinate_frame_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check output items and stall the master side in changing patterns
  initial stall_mode = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    if (cycle_count % 40 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
      2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= (cycle_count[2:0] != 3'd0);
    endcase
  end

  // Payload byte biased toward framing codes and extremes
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0:       return HdrRing;
      1:       return HdrCid;
      2:       return HdrCxy;
      3:       return Trailer;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Append one frame with random content, whole or cut short
  function automatic void add_frame(frame_shape_e shape);
    done_kind_e kind;
    int         n;
    int         junk;
    logic [7:0] b;
    kind = done_kind_e'($urandom_range(1, 3));
    case (kind)
      DONE_RING: stim_q.push_back(HdrRing);
      DONE_CID:  stim_q.push_back(HdrCid);
      default:   stim_q.push_back(HdrCxy);
    endcase
    n = (kind == DONE_CID) ? 1 : 4;
    if (shape == FRAME_TRUNCATED) n = $urandom_range(0, n - 1);
    repeat (n) stim_q.push_back(pick_payload());
    if (shape != FRAME_WHOLE) return;
    // noise while waiting for the trailer, headers included
    junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    repeat (junk) begin
      b = pick_payload();
      stim_q.push_back((b == Trailer) ? 8'h5A : b);
    end
    stim_q.push_back(Trailer);
  endfunction

  // Append a mix of mostly well-formed frames, broken frames and loose noise
  function automatic void add_random(int unsigned target);
    int unsigned stop_at;
    stop_at = stim_q.size() + target;
    while (stim_q.size() < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: add_frame(FRAME_WHOLE);
        7:                   add_frame(FRAME_TRUNCATED);
        8:                   add_frame(FRAME_NO_TRAILER);
        default:             repeat ($urandom_range(1, 3)) stim_q.push_back(8'($urandom));
      endcase
    end
  endfunction

  // Offer one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b);
  endtask

  // Send the queued bytes in bursts separated by random gaps
  task automatic drive_queue();
    int unsigned gap;
    while (stim_q.size() > 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      end
      send_byte(stim_q.pop_front());
      burst_left--;
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Hold off the sender until every expected item has come out
  task automatic wait_drained();
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  initial begin
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    rst_ni          = 1'b0;
    burst_left      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ignored bytes when idle, extreme coordinates, header as colour ID,
    // headers and noise while waiting for the trailer
    stim_q = {8'h00, 8'hFF, Trailer,
              HdrRing, 8'h00, 8'h00, 8'hFF, 8'hFF, Trailer,
              HdrCid, HdrRing, Trailer,
              HdrCxy, 8'hFF, 8'hFF, 8'h00, 8'h00, HdrCid, HdrRing, 8'h12, Trailer};
    drive_queue();
    wait_drained();

    // Random frames, with a full drain in the middle
    add_random(350);
    drive_queue();
    wait_drained();
    add_random(350);
    drive_queue();
    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("summary: %0d bytes sent, %0d result items checked, %0d mismatches",
             sb.bytes_seen, sb.checked, sb.mismatches);
    $display("frames completed: ring %0d, colour id %0d, colour coords %0d",
             sb.kind_count[DONE_RING], sb.kind_count[DONE_CID], sb.kind_count[DONE_CXY]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tcfp_pkg.sv
rtl/tagged_coordinate_frame_parser.sv
tb/tagged_coordinate_frame_parser_tb.sv
